// File: hdl/lsat_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor average threshold: shared definitions
// Sizes, operation codes, register map and the types passed between modules.
// ----------------------------------------------------------------------------
package lsat_pkg;

   localparam int CHANNEL_COUNT     = 11;
   localparam int WINDOW_DEPTH      = 8;
   localparam int CALIBRATION_SCANS = 64;

   localparam int OP_W      = 2;
   localparam int CHANNEL_W = 4;
   localparam int SAMPLE_W  = 10;
   localparam int SUM_W     = 16;
   localparam int ACC_W     = 21;
   localparam int SCAN_W    = 11;
   localparam int MARGIN_W  = 10;

   localparam int RING_DEPTH = CHANNEL_COUNT * WINDOW_DEPTH;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int SLOT_W     = $clog2(WINDOW_DEPTH);

   localparam logic [CHANNEL_W-1:0] LAST_CHANNEL  = CHANNEL_W'(CHANNEL_COUNT - 1);
   localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX    = SAMPLE_W'(1000);
   localparam logic [MARGIN_W-1:0]  MARGIN_RESET  = MARGIN_W'(7);

   // Stream payload widths.
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 24;

   // Register port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-3:0] CSR_IDX_DETECT_MARGIN = '0;

   typedef enum logic [OP_W-1:0] {
      OP_MEASURE    = 2'd0,
      OP_CAL_START  = 2'd1,
      OP_CAL_SAMPLE = 2'd2
   } op_type;

   typedef logic [CHANNEL_COUNT-1:0][SAMPLE_W-1:0] level_array_type;

   typedef struct packed {
      logic                 start;
      logic                 add;
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } calib_cmd_type;

endpackage

// File: hdl/line_sensor_average_threshold.sv
// ----------------------------------------------------------------------------
// Line sensor average threshold detector
// Per-channel moving average of reflectance samples, compared against a
// calibrated baseline plus a programmable margin.
// ----------------------------------------------------------------------------
// Usage: samples enter on the req_ stream, one item per channel reading, in
// scan order. req_tuser carries the operation (measure, start calibration,
// calibration sample); req_tdata carries the channel and the sample. Every
// accepted item yields exactly one rsp_ item: the channel's window average,
// its detection flag, the group flags and the calibration status, all as
// they stand after the item has been applied.
// An item is registered in the working stage and then in the output
// register before it shows on rsp_tvalid. Throughput is one item per cycle
// while the receiver keeps up; the pace is set by the sample ring RAM, which
// is read when an item is taken and written back as it leaves the working
// stage, with a bypass register covering an immediate reuse of the same ring entry.
// Reset clears the ring (through per-entry valid bits), the window sums,
// averages, flags, baselines and calibration state, and loads the margin
// register with 7. No clearing pass is needed; items are taken at once.
// When the receiver stalls, the result waits in the output register and
// one more item can still be taken into the working stage; after that
// req_tready drops until rsp_tready returns.
// ----------------------------------------------------------------------------
module line_sensor_average_threshold (
   input  logic                            clock,
   input  logic                            reset,
   // Input items.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lsat_pkg::REQ_DATA_W-1:0] req_tdata,  // channel[3:0], sample[13:4]
   input  logic [lsat_pkg::REQ_USER_W-1:0] req_tuser,  // operation[1:0]
   // Result items.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // channel_average[9:0], line_seen[10], front_seen[11], right_seen[12],
   // back_seen[13], left_seen[14], any_seen[15], calibrating[16]
   output logic [lsat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Register port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lsat_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [lsat_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [lsat_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready
);
   import lsat_pkg::*;

   // ------------------------------------------------------------------
   // Register port. Only the detection margin lives here.
   // ------------------------------------------------------------------
   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic                csr_hit;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1:2] == CSR_IDX_DETECT_MARGIN);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign margin_in  = (csr_write && csr_hit) ? csr_pwdata[MARGIN_W-1:0] : margin_ff;
   assign csr_prdata = csr_hit ? CSR_DW'(margin_ff) : '0;

   // ------------------------------------------------------------------
   // Intake stage: decode the item, choose the ring entry and start the
   // RAM read. The ring slot moves on when a measurement of the last
   // channel is taken, so the next item already sees the new slot.
   // ------------------------------------------------------------------
   op_type               req_op;
   logic [CHANNEL_W-1:0] req_channel;
   logic [SAMPLE_W-1:0]  req_sample;
   logic                 req_chan_ok;
   logic                 req_accept;
   logic [RING_AW-1:0]   req_addr;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 ram_rd_en;

   assign req_op      = op_type'(req_tuser);
   assign req_channel = req_tdata[CHANNEL_W-1:0];
   assign req_sample  = req_tdata[CHANNEL_W +: SAMPLE_W];
   assign req_chan_ok = (req_channel <= LAST_CHANNEL);
   assign req_accept  = req_tvalid && req_tready;
   assign req_addr    = RING_AW'(req_channel) * RING_AW'(WINDOW_DEPTH) + RING_AW'(slot_ff);
   assign ram_rd_en   = req_accept && (req_op == OP_MEASURE) && req_chan_ok;

   always_comb begin
      slot_in = slot_ff;
      if (req_accept && (req_op == OP_MEASURE) && (req_channel == LAST_CHANNEL)) begin
         if (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Working stage registers.
   // ------------------------------------------------------------------
   logic                 s1_valid_ff, s1_valid_in;
   op_type               s1_op_ff;
   logic [CHANNEL_W-1:0] s1_channel_ff;
   logic [SAMPLE_W-1:0]  s1_sample_ff;
   logic                 s1_chan_ok_ff;
   logic [RING_AW-1:0]   s1_addr_ff;
   logic                 s1_advance;
   logic                 s1_measure;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign s1_measure = (s1_op_ff == OP_MEASURE) && s1_chan_ok_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Sample ring: one RAM holding every channel's window. An entry that
   // was never written reads as zero through its valid bit. The last
   // write is held so that an item touching the entry just written gets
   // the new value rather than the RAM's stale read.
   // ------------------------------------------------------------------
   logic                  ram_wr_en;
   logic [SAMPLE_W-1:0]   ram_rd_data;
   logic [RING_DEPTH-1:0] ring_valid_ff, ring_valid_in;
   logic                  wr_valid_ff;
   logic [RING_AW-1:0]    wr_addr_ff;
   logic [SAMPLE_W-1:0]   wr_data_ff;
   logic [SAMPLE_W-1:0]   sat_sample;
   logic [SAMPLE_W-1:0]   old_sample;
   logic                  fwd_hit;

   assign sat_sample = (s1_sample_ff > SAMPLE_MAX) ? SAMPLE_MAX : s1_sample_ff;
   assign ram_wr_en  = s1_advance && s1_measure;
   assign fwd_hit    = wr_valid_ff && (wr_addr_ff == s1_addr_ff);

   lsat_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (sat_sample),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      old_sample = '0;
      if (fwd_hit) begin
         old_sample = wr_data_ff;
      end else if (s1_measure && ring_valid_ff[s1_addr_ff]) begin
         old_sample = ram_rd_data;
      end
   end

   always_comb begin
      ring_valid_in = ring_valid_ff;
      if (ram_wr_en) begin
         ring_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Calibration.
   // ------------------------------------------------------------------
   calib_cmd_type   calib_cmd;
   level_array_type baselines;
   logic            calib_active_next;

   always_comb begin
      calib_cmd.start   = s1_advance && (s1_op_ff == OP_CAL_START);
      calib_cmd.add     = s1_advance && (s1_op_ff == OP_CAL_SAMPLE) && s1_chan_ok_ff;
      calib_cmd.channel = s1_channel_ff;
      calib_cmd.sample  = sat_sample;
   end

   lsat_calib u_calib (
      .clock       (clock),
      .reset       (reset),
      .cmd         (calib_cmd),
      .baselines   (baselines),
      .active_next (calib_active_next)
   );

   // ------------------------------------------------------------------
   // Window sums, averages and flags. The sum swaps the outgoing sample
   // for the incoming one; the average is the sum truncated by the window
   // depth; the flag compares it with baseline plus margin.
   // ------------------------------------------------------------------
   logic [CHANNEL_COUNT-1:0][SUM_W-1:0]    sums_ff, sums_in;
   logic [CHANNEL_COUNT-1:0][SAMPLE_W-1:0] avg_ff, avg_in;
   logic [CHANNEL_COUNT-1:0]               flags_ff, flags_in;
   logic [SUM_W-1:0]                       sum_new;
   logic [SAMPLE_W-1:0]                    avg_new;
   logic [MARGIN_W:0]                      limit;
   logic                                   flag_new;

   always_comb begin
      sums_in  = sums_ff;
      avg_in   = avg_ff;
      flags_in = flags_ff;
      sum_new  = '0;
      avg_new  = '0;
      limit    = '0;
      flag_new = 1'b0;
      if (s1_measure) begin
         sum_new  = sums_ff[s1_channel_ff] - SUM_W'(old_sample) + SUM_W'(sat_sample);
         avg_new  = SAMPLE_W'(sum_new / WINDOW_DEPTH);
         limit    = (MARGIN_W+1)'(baselines[s1_channel_ff]) + (MARGIN_W+1)'(margin_ff);
         flag_new = ((MARGIN_W+1)'(avg_new) > limit);
         if (s1_advance) begin
            sums_in[s1_channel_ff]  = sum_new;
            avg_in[s1_channel_ff]   = avg_new;
            flags_in[s1_channel_ff] = flag_new;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0] out_avg;
   logic                out_line;
   logic                front_seen, right_seen, back_seen, left_seen, any_seen;

   always_comb begin
      out_avg  = '0;
      out_line = 1'b0;
      if (s1_chan_ok_ff) begin
         out_avg  = avg_in[s1_channel_ff];
         out_line = flags_in[s1_channel_ff];
      end
   end

   assign front_seen = |flags_in[1:0];
   assign right_seen = |flags_in[4:2];
   assign back_seen  = |flags_in[7:5];
   assign left_seen  = |flags_in[10:8];
   assign any_seen   = |flags_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({calib_active_next, any_seen, left_seen, back_seen,
                                     right_seen, front_seen, out_line, out_avg});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff     <= MARGIN_RESET;
         slot_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ring_valid_ff <= '0;
         wr_valid_ff   <= 1'b0;
         sums_ff       <= '0;
         avg_ff        <= '0;
         flags_ff      <= '0;
      end else begin
         margin_ff     <= margin_in;
         slot_ff       <= slot_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ring_valid_ff <= ring_valid_in;
         wr_valid_ff   <= wr_valid_ff || ram_wr_en;
         sums_ff       <= sums_in;
         avg_ff        <= avg_in;
         flags_ff      <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff      <= req_op;
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample;
         s1_chan_ok_ff <= req_chan_ok;
         s1_addr_ff    <= req_addr;
      end
      if (ram_wr_en) begin
         wr_addr_ff <= s1_addr_ff;
         wr_data_ff <= sat_sample;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A stalled working stage must not lose its RAM read data.
   a_no_read_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |-> !ram_rd_en)
      else $error("ring read issued while the working stage is stalled");

   // A flagged channel always has a nonzero average.
   a_flag_needs_average: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[SAMPLE_W]) |-> (rsp_data_ff[SAMPLE_W-1:0] != '0))
      else $error("line flagged with a zero average");

   // Reset empties the ring.
   a_reset_clears_ring: assert property (@(posedge clock)
      reset |=> (ring_valid_ff == '0))
      else $error("ring valid bits not cleared by reset");

   // The group flags agree with the overall flag.
   a_any_matches_groups: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[SAMPLE_W+5] ==
         (rsp_data_ff[SAMPLE_W+1] || rsp_data_ff[SAMPLE_W+2] ||
          rsp_data_ff[SAMPLE_W+3] || rsp_data_ff[SAMPLE_W+4])))
      else $error("any_seen disagrees with the group flags");
`endif

endmodule

// File: hdl/lsat_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lsat_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 88
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lsat_calib.sv
// ----------------------------------------------------------------------------
// Line sensor average threshold: baseline calibration
// Sums calibration samples per channel over a fixed number of scans and
// turns the sums into baselines.
// ----------------------------------------------------------------------------
module lsat_calib (
   input  logic                      clock,
   input  logic                      reset,
   input  lsat_pkg::calib_cmd_type   cmd,
   output lsat_pkg::level_array_type baselines,
   output logic                      active_next
);
   import lsat_pkg::*;

   logic [CHANNEL_COUNT-1:0][ACC_W-1:0] acc_ff, acc_in;
   logic [SCAN_W-1:0]                   count_ff, count_in;
   logic                                active_ff, active_in;
   level_array_type                     base_ff, base_in;

   always_comb begin
      acc_in    = acc_ff;
      count_in  = count_ff;
      active_in = active_ff;
      base_in   = base_ff;
      if (cmd.start) begin
         acc_in    = '0;
         count_in  = '0;
         active_in = 1'b1;
      end else if (cmd.add && active_ff) begin
         acc_in[cmd.channel] = acc_ff[cmd.channel] + ACC_W'(cmd.sample);
         // The scan closes with the last channel.
         if (cmd.channel == LAST_CHANNEL) begin
            count_in = count_ff + SCAN_W'(1);
            if (count_in >= SCAN_W'(CALIBRATION_SCANS)) begin
               for (int k = 0; k < CHANNEL_COUNT; k++) begin
                  base_in[k] = SAMPLE_W'(acc_in[k] / CALIBRATION_SCANS);
               end
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         count_ff  <= '0;
         active_ff <= 1'b0;
         base_ff   <= '0;
      end else begin
         acc_ff    <= acc_in;
         count_ff  <= count_in;
         active_ff <= active_in;
         base_ff   <= base_in;
      end
   end

   assign baselines   = base_ff;
   assign active_next = active_in;

endmodule

// File: bench/line_sensor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line sensor checker
// Watches the input, result and register ports of the detector. It keeps its
// own copy of the sensor state, predicts one reading per accepted item and
// compares each returned reading field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module line_sensor_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lsat_pkg::REQ_DATA_W-1:0] req_tdata,  // channel[3:0], sample[13:4]
   input  logic [lsat_pkg::REQ_USER_W-1:0] req_tuser,  // operation[1:0]
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // channel_average[9:0], line_seen[10], front_seen[11], right_seen[12],
   // back_seen[13], left_seen[14], any_seen[15], calibrating[16]
   input  logic [lsat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lsat_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [lsat_pkg::CSR_DW-1:0]     csr_pwdata,
   input  logic [lsat_pkg::CSR_DW-1:0]     csr_prdata,
   input  logic                            csr_pready,
   output int                              mismatch_count,
   output int                              pending_count
);
   import lsat_pkg::*;

   localparam logic [CSR_AW-1:0] MARGIN_ADDR = CSR_AW'(4 * CSR_IDX_DETECT_MARGIN);

   typedef struct packed {
      logic                calibrating;
      logic                any_seen;
      logic                left_seen;
      logic                back_seen;
      logic                right_seen;
      logic                front_seen;
      logic                line_seen;
      logic [SAMPLE_W-1:0] channel_average;
   } reading_type;

   reading_type expected_readings[$];

   logic [SAMPLE_W-1:0]      sample_window [CHANNEL_COUNT][WINDOW_DEPTH];
   logic [SUM_W-1:0]         window_total [CHANNEL_COUNT];
   logic [SAMPLE_W-1:0]      channel_avg [CHANNEL_COUNT];
   logic [SAMPLE_W-1:0]      baseline [CHANNEL_COUNT];
   logic [ACC_W-1:0]         calib_total [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] line_flags;
   logic [MARGIN_W-1:0]      margin;
   int unsigned              ring_pos;
   int unsigned              scans_done;
   bit                       calib_running;
   int                       errors = 0;

   task automatic clear_sensor_state();
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         for (int w = 0; w < WINDOW_DEPTH; w++)
            sample_window[c][w] = '0;
         window_total[c] = '0;
         channel_avg[c]  = '0;
         baseline[c]     = '0;
         calib_total[c]  = '0;
      end
      line_flags    = '0;
      ring_pos      = 0;
      scans_done    = 0;
      calib_running = 1'b0;
      margin        = MARGIN_RESET;
   endtask

   // Applies one item to the sensor state and queues the reading it yields.
   task automatic predict_reading(input logic [OP_W-1:0]      op,
                                  input logic [CHANNEL_W-1:0] ch,
                                  input logic [SAMPLE_W-1:0]  raw);
      logic [SAMPLE_W-1:0] level;
      logic [SAMPLE_W-1:0] oldest;
      reading_type         r;
      bit                  known;
      known = ch < CHANNEL_COUNT;
      level = (raw > SAMPLE_MAX) ? SAMPLE_MAX : raw;
      case (op)
         OP_CAL_START: begin
            for (int c = 0; c < CHANNEL_COUNT; c++)
               calib_total[c] = '0;
            scans_done    = 0;
            calib_running = 1'b1;
         end
         OP_MEASURE: if (known) begin
            oldest = sample_window[ch][ring_pos];
            sample_window[ch][ring_pos] = level;
            window_total[ch] = window_total[ch] - oldest + level;
            channel_avg[ch]  = SAMPLE_W'(window_total[ch] / WINDOW_DEPTH);
            line_flags[ch]   = int'(channel_avg[ch]) > int'(baseline[ch]) + int'(margin);
            if (ch == LAST_CHANNEL)
               ring_pos = (ring_pos + 1) % WINDOW_DEPTH;
         end
         OP_CAL_SAMPLE: if (known && calib_running) begin
            calib_total[ch] = calib_total[ch] + level;
            if (ch == LAST_CHANNEL) begin
               scans_done++;
               if (scans_done >= CALIBRATION_SCANS) begin
                  for (int c = 0; c < CHANNEL_COUNT; c++)
                     baseline[c] = SAMPLE_W'(calib_total[c] / CALIBRATION_SCANS);
                  calib_running = 1'b0;
               end
            end
         end
         default: ;
      endcase
      r.channel_average = known ? channel_avg[ch] : '0;
      r.line_seen       = known ? line_flags[ch] : 1'b0;
      r.front_seen      = |line_flags[1:0];
      r.right_seen      = |line_flags[4:2];
      r.back_seen       = |line_flags[7:5];
      r.left_seen       = |line_flags[10:8];
      r.any_seen        = |line_flags;
      r.calibrating     = calib_running;
      expected_readings.push_back(r);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   initial clear_sensor_state();

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         clear_sensor_state();
         expected_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: reading %h arrived with no item pending", $time, rsp_tdata);
            end else begin
               want = expected_readings.pop_front();
               check_field("channel_average", want.channel_average, rsp_tdata[9:0]);
               check_field("line_seen", want.line_seen, rsp_tdata[10]);
               check_field("front_seen", want.front_seen, rsp_tdata[11]);
               check_field("right_seen", want.right_seen, rsp_tdata[12]);
               check_field("back_seen", want.back_seen, rsp_tdata[13]);
               check_field("left_seen", want.left_seen, rsp_tdata[14]);
               check_field("any_seen", want.any_seen, rsp_tdata[15]);
               check_field("calibrating", want.calibrating, rsp_tdata[16]);
               check_field("padding", 0, rsp_tdata[RSP_DATA_W-1:17]);
            end
         end
         if (csr_psel && csr_penable && csr_pready && csr_paddr == MARGIN_ADDR) begin
            if (csr_pwrite)
               margin = csr_pwdata[MARGIN_W-1:0];
            else
               check_field("detect_margin readback", margin, csr_prdata);
         end
         if (req_tvalid && req_tready)
            predict_reading(req_tuser, req_tdata[CHANNEL_W-1:0],
                            req_tdata[CHANNEL_W +: SAMPLE_W]);
      end
      mismatch_count <= errors;
      pending_count  <= expected_readings.size();
   end

endmodule

// File: bench/tb_line_sensor_average_threshold.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line sensor average threshold testbench
// Drives sensor scans, calibrations and margin settings into the detector
// with random gaps and back-pressure, while a separate checker predicts and
// compares every reading. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_line_sensor_average_threshold;
   import lsat_pkg::*;

   // A watchdog ends the run after this many cycles without any handshake.
   localparam int QUIET_LIMIT   = 2000;
   // Cycles allowed after the last reading, to let the pipeline settle.
   localparam int SETTLE_CYCLES = 6;
   // The one operation code the block must ignore.
   localparam logic [OP_W-1:0]   OP_RESERVED = 2'd3;
   localparam logic [CSR_AW-1:0] MARGIN_ADDR = CSR_AW'(4 * CSR_IDX_DETECT_MARGIN);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // channel[3:0], sample[13:4]
   logic [REQ_USER_W-1:0] req_tuser = '0;  // operation[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // channel_average[9:0], line_seen[10], front_seen[11], right_seen[12],
   // back_seen[13], left_seen[14], any_seen[15], calibrating[16]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int pending_count;
   int quiet_cycles = 0;

   // When set, neither the sender nor the receiver inserts idle cycles.
   bit calm = 1'b0;

   // Nominal reflectance of each channel, and the center of each sample
   // in the scan being sent.
   int cal_level [CHANNEL_COUNT];
   int scan_center [CHANNEL_COUNT];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   line_sensor_average_threshold uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   line_sensor_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // The receiver stalls at random, about 27 percent of the time, except in the
   // calm stretch.
   always @(posedge clock) begin
      rsp_tready <= calm || $urandom_range(99) >= 27;
   end

   // Any accepted item on either channel shows the block is still alive.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offers one item and returns at the edge where it is accepted. Idle
   // cycles before the item carry random data with tvalid low, so the block
   // must ignore whatever sits on the bus then.
   task automatic send_item(input logic [OP_W-1:0]      op,
                            input logic [CHANNEL_W-1:0] ch,
                            input logic [SAMPLE_W-1:0]  smp);
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_W'($urandom);
         req_tuser  <= REQ_USER_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, smp, ch};
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // A stray item: any operation, any channel code, any sample code. Starts
   // are turned into the reserved code where they would cut a calibration.
   task automatic send_noise(input bit allow_start);
      logic [OP_W-1:0] op;
      op = OP_W'($urandom_range(3));
      if (op == OP_CAL_START && !allow_start)
         op = OP_RESERVED;
      send_item(op, CHANNEL_W'($urandom_range(15)), SAMPLE_W'($urandom_range(1023)));
   endtask

   // One scan of channels 0 to 10 in order, each sample spread around its
   // center and clamped to the converter range, with the odd stray item.
   task automatic send_scan(input logic [OP_W-1:0] op, input int spread,
                            input bit allow_start);
      int value;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if ($urandom_range(99) < 5)
            send_noise(allow_start);
         value = scan_center[c] + int'($urandom_range(2 * spread)) - spread;
         if (value < 0)
            value = 0;
         if (value > 1000)
            value = 1000;
         send_item(op, CHANNEL_W'(c), SAMPLE_W'(value));
      end
   endtask

   // Measure scans where each channel either sees a line (well above its
   // nominal level) or bare floor (slightly below), re-chosen every four
   // scans so the window averages cross the threshold both ways.
   task automatic measure_phase(input int scan_total);
      for (int n = 0; n < scan_total; n++) begin
         if (n % 4 == 0)
            for (int c = 0; c < CHANNEL_COUNT; c++)
               scan_center[c] = cal_level[c] + ($urandom_range(1) ? 60 : -10);
         send_scan(OP_MEASURE, 15, 1'b1);
      end
   endtask

   // Stops sending and waits until every reading has come back, then lets
   // the pipeline settle.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the margin register, then reads it back in the following
   // transfer; the checker compares the read data.
   task automatic set_margin(input logic [MARGIN_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MARGIN_ADDR;
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset margin, with all baselines still zero.
      // Field extremes first: smallest and largest samples, and readings
      // above 1000 that the block must clamp.
      send_item(OP_MEASURE, 4'd0, 10'd0);
      send_item(OP_MEASURE, 4'd1, 10'd1000);
      send_item(OP_MEASURE, 4'd2, 10'd1023);
      send_item(OP_MEASURE, 4'd3, 10'd1001);
      // The last channel moves the ring to its next slot.
      send_item(OP_MEASURE, 4'd10, 10'd512);
      // Channel codes past the last sensor change nothing and read as zero.
      send_item(OP_MEASURE, 4'd11, 10'd700);
      send_item(OP_MEASURE, 4'd15, 10'd1023);
      // The reserved operation is ignored.
      send_item(OP_RESERVED, 4'd4, 10'd300);
      // A calibration sample with no calibration running is ignored.
      send_item(OP_CAL_SAMPLE, 4'd5, 10'd999);
      // A start ignores its channel and sample fields.
      send_item(OP_CAL_START, 4'd15, 10'd1023);
      send_item(OP_CAL_SAMPLE, 4'd0, 10'd100);
      // Measuring during a calibration works as usual.
      send_item(OP_MEASURE, 4'd1, 10'd1000);
      send_item(OP_CAL_SAMPLE, 4'd12, 10'd40);
      // A second start restarts the running calibration.
      send_item(OP_CAL_START, 4'd7, 10'd5);
      send_item(OP_CAL_SAMPLE, 4'd10, 10'd1000);
      send_item(OP_RESERVED, 4'd10, 10'd0);
      send_item(OP_MEASURE, 4'd4, 10'd682);
      send_item(OP_MEASURE, 4'd5, 10'd341);
      wait_for_results();

      // Nominal levels: one channel on black, one at full white, the others
      // between 100 and 850.
      foreach (cal_level[c])
         cal_level[c] = $urandom_range(100, 850);
      cal_level[0] = 0;
      cal_level[1] = 1000;

      // Measure scans against zero baselines with a moderate margin.
      set_margin(10'd25);
      measure_phase(10);
      wait_for_results();

      // Calibration at the zero margin. The first attempt is cut short by a
      // restart; the second runs to completion with measure scans mixed in.
      // The middle of it runs with no idle cycles on either side.
      set_margin(10'd0);
      foreach (scan_center[c])
         scan_center[c] = cal_level[c];
      send_item(OP_CAL_START, CHANNEL_W'($urandom_range(15)), SAMPLE_W'($urandom_range(1023)));
      send_scan(OP_CAL_SAMPLE, 20, 1'b0);
      send_scan(OP_CAL_SAMPLE, 20, 1'b0);
      send_item(OP_CAL_START, CHANNEL_W'($urandom_range(15)), SAMPLE_W'($urandom_range(1023)));
      for (int n = 0; n < CALIBRATION_SCANS; n++) begin
         if (n == 20)
            calm <= 1'b1;
         if (n == 45)
            calm <= 1'b0;
         if ($urandom_range(9) == 0)
            send_scan(OP_MEASURE, 20, 1'b0);
         send_scan(OP_CAL_SAMPLE, 20, 1'b0);
      end

      // Detection against the new baselines with no margin at all.
      measure_phase(15);
      wait_for_results();

      // The largest margin in range, and the largest the field can hold:
      // nothing may be flagged by new samples.
      set_margin(10'd1000);
      measure_phase(5);
      wait_for_results();
      set_margin(10'd1023);
      measure_phase(3);
      wait_for_results();

      // A small random margin, close to the line contrast.
      set_margin(MARGIN_W'($urandom_range(1, 60)));
      measure_phase(15);
      wait_for_results();

      if (mismatch_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
